FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, held off during reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen out of reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: design/lbds_pkg.sv
`default_nettype none

package lbds_pkg;

  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int DIM_W     = 11;
  localparam int BLK_W     = 5;
  localparam int ROW_W     = 11;
  localparam int HEIGHT_MAX = 1024;

  localparam int SUM_W     = 16;
  localparam int LUMA_W    = 8;
  localparam int LUMA_ACC_W = 24;
  localparam int LEVEL_W   = 3;
  localparam int NUM_LEVELS = 8;
  localparam int LEVEL_SHIFT = 5;
  localparam int CHAR_W    = 7;

  localparam logic [LUMA_ACC_W-1:0] RED_COEF   = 24'd19595;
  localparam logic [LUMA_ACC_W-1:0] GREEN_COEF = 24'd38470;
  localparam logic [LUMA_ACC_W-1:0] BLUE_COEF  = 24'd7471;

  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_BLOCK_W      = 3'd2;
  localparam logic [2:0] REG_BLOCK_H      = 3'd3;
  localparam logic [2:0] REG_INVERT_MODE  = 3'd4;

  localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST  = 11'd64;
  localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST = 11'd64;
  localparam logic [BLK_W-1:0] BLOCK_W_RST      = 5'd1;
  localparam logic [BLK_W-1:0] BLOCK_H_RST      = 5'd1;

  // darkest to lightest: @ # % * | - . space
  localparam logic [CHAR_W-1:0] SHADE_LUT [NUM_LEVELS] = '{
    7'h40, 7'h23, 7'h25, 7'h2A, 7'h7C, 7'h2D, 7'h2E, 7'h20
  };

  typedef struct packed {
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic [BLK_W-1:0] block_w;
    logic [BLK_W-1:0] block_h;
    logic             invert_mode;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LUMA,
    ST_ACC,
    ST_LEVEL
  } state_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic luma_en;
    logic acc_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic emit;
    logic out_free;
  } sts_t;

  function automatic logic [CHAR_W-1:0] shade_of(input logic [LEVEL_W-1:0] lvl);
    return SHADE_LUT[lvl];
  endfunction

endpackage

`default_nettype wire

FILE: design/lbds_ctrl.sv
`default_nettype none

module lbds_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire lbds_pkg::sts_t sts,
  output lbds_pkg::cmd_t     cmd
);

  lbds_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lbds_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lbds_pkg::ST_CLEAR: begin
        if (sts.clear_last) state_nxt = lbds_pkg::ST_IDLE;
      end
      lbds_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = lbds_pkg::ST_LUMA;
      end
      lbds_pkg::ST_LUMA: state_nxt = lbds_pkg::ST_ACC;
      lbds_pkg::ST_ACC:  state_nxt = lbds_pkg::ST_LEVEL;
      lbds_pkg::ST_LEVEL: begin
        if (!sts.emit || sts.out_free) state_nxt = lbds_pkg::ST_IDLE;
      end
      default: state_nxt = lbds_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      lbds_pkg::ST_CLEAR: cmd.clear = 1'b1;
      lbds_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      lbds_pkg::ST_LUMA: cmd.luma_en = 1'b1;
      lbds_pkg::ST_ACC:  cmd.acc_en  = 1'b1;
      lbds_pkg::ST_LEVEL: cmd.out_load = sts.emit && sts.out_free;
      default: begin
        cmd      = '0;
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/lbds_dp.sv
`default_nettype none

module lbds_dp #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_BLOCK = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire lbds_pkg::cfg_t                     cfg,
  input  wire lbds_pkg::cmd_t                     cmd,
  output lbds_pkg::sts_t                          sts,
  input  wire logic [7:0]                         in_red,
  input  wire logic [7:0]                         in_green,
  input  wire logic [7:0]                         in_blue,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [lbds_pkg::CHAR_W-1:0]             out_shade_char,
  output logic                                    out_end_of_line
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int BW  = $clog2(MAX_BLOCK + 1);
  localparam int HW  = lbds_pkg::ROW_W;
  localparam int PW  = CW + BW + 1;
  localparam int ARW = 2 * BW;
  localparam int THW = ARW + lbds_pkg::LEVEL_SHIFT + lbds_pkg::LEVEL_W;
  localparam int SW  = lbds_pkg::SUM_W;
  localparam int LW  = lbds_pkg::LEVEL_W;
  localparam int NTH = lbds_pkg::NUM_LEVELS - 1;

  // effective sizes: zero acts as one, oversize clamps
  logic [CW-1:0] w;
  logic [HW-1:0] h;
  logic [BW-1:0] bw, bh;

  always_comb begin
    if (cfg.image_width == '0) begin
      w = CW'(1);
    end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
      w = CW'(MAX_WIDTH);
    end else begin
      w = CW'(cfg.image_width);
    end
    if (cfg.image_height == '0) begin
      h = HW'(1);
    end else if (32'(cfg.image_height) > 32'(lbds_pkg::HEIGHT_MAX)) begin
      h = HW'(lbds_pkg::HEIGHT_MAX);
    end else begin
      h = HW'(cfg.image_height);
    end
    if (cfg.block_w == '0) begin
      bw = BW'(1);
    end else if (32'(cfg.block_w) > 32'(MAX_BLOCK)) begin
      bw = BW'(MAX_BLOCK);
    end else begin
      bw = BW'(cfg.block_w);
    end
    if (cfg.block_h == '0) begin
      bh = BW'(1);
    end else if (32'(cfg.block_h) > 32'(MAX_BLOCK)) begin
      bh = BW'(MAX_BLOCK);
    end else begin
      bh = BW'(cfg.block_h);
    end
  end

  // raster position counters
  logic [CW-1:0] pix_col_r, pix_col_nxt;
  logic [HW-1:0] pix_row_r, pix_row_nxt;
  logic [BW-1:0] tco_r, tco_nxt;
  logic [BW-1:0] tro_r, tro_nxt;
  logic [CW-1:0] cell_r, cell_nxt;

  always_comb begin
    pix_col_nxt = pix_col_r;
    pix_row_nxt = pix_row_r;
    tco_nxt     = tco_r;
    tro_nxt     = tro_r;
    cell_nxt    = cell_r;
    if (cmd.accept) begin
      if (32'(pix_col_r) + 32'd1 >= 32'(w)) begin
        pix_col_nxt = '0;
        tco_nxt     = '0;
        cell_nxt    = '0;
        if (32'(pix_row_r) + 32'd1 >= 32'(h)) begin
          pix_row_nxt = '0;
          tro_nxt     = '0;
        end else begin
          pix_row_nxt = pix_row_r + HW'(1);
          if (32'(tro_r) + 32'd1 >= 32'(bh)) begin
            tro_nxt = '0;
          end else begin
            tro_nxt = tro_r + BW'(1);
          end
        end
      end else begin
        pix_col_nxt = pix_col_r + CW'(1);
        if (32'(tco_r) + 32'd1 >= 32'(bw)) begin
          tco_nxt = '0;
          if (32'(cell_r) < 32'(MAX_WIDTH)) cell_nxt = cell_r + CW'(1);
        end else begin
          tco_nxt = tco_r + BW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_col_r <= '0;
      pix_row_r <= '0;
      tco_r     <= '0;
      tro_r     <= '0;
      cell_r    <= '0;
    end else begin
      pix_col_r <= pix_col_nxt;
      pix_row_r <= pix_row_nxt;
      tco_r     <= tco_nxt;
      tro_r     <= tro_nxt;
      cell_r    <= cell_nxt;
    end
  end

  // beat capture
  logic [7:0]    red_r, green_r, blue_r;
  logic [CW-1:0] s_cell_r;
  logic [BW-1:0] s_tco_r, s_tro_r;
  logic [HW-1:0] s_row_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      red_r    <= in_red;
      green_r  <= in_green;
      blue_r   <= in_blue;
      s_cell_r <= cell_r;
      s_tco_r  <= tco_r;
      s_tro_r  <= tro_r;
      s_row_r  <= pix_row_r;
    end
  end

  // luma and tile bookkeeping
  logic [lbds_pkg::LUMA_ACC_W-1:0] luma_full;
  logic [PW-1:0]                   cell_end;
  logic                            band_ok, cell_ok;

  logic [lbds_pkg::LUMA_W-1:0] luma_r;
  logic                        valid_r, restart_r, tile_end_r, eol_r;
  logic [AW-1:0]               addr_r;
  logic [ARW-1:0]              area_r;

  always_comb begin
    luma_full = lbds_pkg::RED_COEF   * lbds_pkg::LUMA_ACC_W'(red_r)
              + lbds_pkg::GREEN_COEF * lbds_pkg::LUMA_ACC_W'(green_r)
              + lbds_pkg::BLUE_COEF  * lbds_pkg::LUMA_ACC_W'(blue_r);
    band_ok = (32'(s_tro_r) <= 32'(s_row_r)) &&
              (32'(s_row_r) - 32'(s_tro_r) + 32'(bh) <= 32'(h));
    cell_end = (PW'(s_cell_r) + PW'(1)) * PW'(bw);
    cell_ok  = cell_end <= PW'(w);
  end

  always_ff @(posedge clk) begin
    if (cmd.luma_en) begin
      luma_r     <= luma_full[lbds_pkg::LUMA_ACC_W-1 -: lbds_pkg::LUMA_W];
      valid_r    <= band_ok && cell_ok;
      restart_r  <= (s_tro_r == '0) && (s_tco_r == '0);
      tile_end_r <= (s_tco_r == bw - BW'(1)) && (s_tro_r == bh - BW'(1));
      eol_r      <= (cell_end + PW'(bw)) > PW'(w);
      addr_r     <= s_cell_r[AW-1:0];
      area_r     <= ARW'(bw) * ARW'(bh);
    end
  end

  // column sum memory
  logic [SW-1:0] col_mem [MAX_WIDTH];
  logic [SW-1:0] rd_data_r;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [SW-1:0] mem_wdata;

  logic [SW:0]   sum_full;
  logic [SW-1:0] sum_sat;

  always_comb begin
    if (restart_r) begin
      sum_full = (SW + 1)'(luma_r);
    end else begin
      sum_full = (SW + 1)'(rd_data_r) + (SW + 1)'(luma_r);
    end
    sum_sat = sum_full[SW] ? {SW{1'b1}} : sum_full[SW-1:0];

    mem_we    = cmd.clear || (cmd.acc_en && valid_r);
    mem_waddr = cmd.clear ? clr_addr_r : addr_r;
    mem_wdata = cmd.clear ? '0 : sum_sat;

    clr_addr_nxt = clr_addr_r;
    if (cmd.clear) begin
      clr_addr_nxt = (clr_addr_r == AW'(MAX_WIDTH - 1)) ? '0 : clr_addr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) col_mem[mem_waddr] <= mem_wdata;
    if (cmd.accept) rd_data_r <= col_mem[cell_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else begin
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // level thresholds: k * area * 32
  logic [SW-1:0]  sum_r;
  logic           emit_r;
  logic           oeol_r;
  logic [THW-1:0] thr_nxt [NTH];
  logic [THW-1:0] thr_r   [NTH];

  always_comb begin
    for (int k = 0; k < NTH; k++) begin
      thr_nxt[k] = (THW'(area_r) * THW'(k + 1)) << lbds_pkg::LEVEL_SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      sum_r  <= sum_sat;
      oeol_r <= eol_r;
      thr_r  <= thr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_r <= 1'b0;
    end else if (cmd.acc_en) begin
      emit_r <= valid_r && tile_end_r;
    end
  end

  logic [LW-1:0] level;
  logic [LW-1:0] shade_idx;

  always_comb begin
    level = '0;
    for (int k = 0; k < NTH; k++) begin
      if (32'(sum_r) >= 32'(thr_r[k])) level = LW'(k + 1);
    end
    shade_idx = cfg.invert_mode ? ~level : level;
  end

  // result register
  logic                          out_valid_r, out_valid_nxt;
  logic [lbds_pkg::CHAR_W-1:0]   out_char_r;
  logic                          out_eol_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_char_r <= lbds_pkg::shade_of(shade_idx);
      out_eol_r  <= oeol_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_shade_char  = out_char_r;
  assign out_end_of_line = out_eol_r;

  assign sts.clear_last = clr_addr_r == AW'(MAX_WIDTH - 1);
  assign sts.emit       = emit_r;
  assign sts.out_free   = !out_valid_r || !out_stall;

endmodule

`default_nettype wire

FILE: design/luma_box_downscale_ascii_shade_unit.sv
`default_nettype none

// Luma box downscaler with ASCII shade output. Takes RGB pixels in raster order, sums
// floored Q16 luma over block_w x block_h tiles and emits one shade character per full
// tile ("@#%*|-. " dark to light, reversed when invert_mode is set), with end_of_line on
// the last cell of each output row; partial tiles at the right and bottom are dropped.
// Each pixel goes through four steps (accept, luma and column-sum read, accumulate and
// write back, level and output), one at a time for the read-modify-write of the single
// column-sum memory; a finished result waits in an output register and only holds up a
// later pixel that also produces a result. After reset the column-sum memory is cleared
// before the first pixel is taken. Registers sit at byte addresses 0, 4, 8, 12, 16:
// image_width, image_height, block_w, block_h, invert_mode; write them only while idle.

module luma_box_downscale_ascii_shade_unit #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_BLOCK = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,

  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [lbds_pkg::ADDR_W-1:0]       paddr,
  input  wire logic [lbds_pkg::DATA_W-1:0]       pwdata,
  output logic      [lbds_pkg::DATA_W-1:0]       prdata,
  output logic                                   pready,

  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [7:0]                        in_red,
  input  wire logic [7:0]                        in_green,
  input  wire logic [7:0]                        in_blue,

  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [lbds_pkg::CHAR_W-1:0]            out_shade_char,
  output logic                                   out_end_of_line
);

  lbds_pkg::cfg_t cfg_r, cfg_nxt;
  lbds_pkg::cmd_t cmd;
  lbds_pkg::sts_t sts;
  logic [2:0]     reg_idx;
  logic           wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        lbds_pkg::REG_IMAGE_WIDTH:  cfg_nxt.image_width  = pwdata[lbds_pkg::DIM_W-1:0];
        lbds_pkg::REG_IMAGE_HEIGHT: cfg_nxt.image_height = pwdata[lbds_pkg::DIM_W-1:0];
        lbds_pkg::REG_BLOCK_W:      cfg_nxt.block_w      = pwdata[lbds_pkg::BLK_W-1:0];
        lbds_pkg::REG_BLOCK_H:      cfg_nxt.block_h      = pwdata[lbds_pkg::BLK_W-1:0];
        lbds_pkg::REG_INVERT_MODE:  cfg_nxt.invert_mode  = pwdata[0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= lbds_pkg::IMAGE_WIDTH_RST;
      cfg_r.image_height <= lbds_pkg::IMAGE_HEIGHT_RST;
      cfg_r.block_w      <= lbds_pkg::BLOCK_W_RST;
      cfg_r.block_h      <= lbds_pkg::BLOCK_H_RST;
      cfg_r.invert_mode  <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      lbds_pkg::REG_IMAGE_WIDTH:  prdata = lbds_pkg::DATA_W'(cfg_r.image_width);
      lbds_pkg::REG_IMAGE_HEIGHT: prdata = lbds_pkg::DATA_W'(cfg_r.image_height);
      lbds_pkg::REG_BLOCK_W:      prdata = lbds_pkg::DATA_W'(cfg_r.block_w);
      lbds_pkg::REG_BLOCK_H:      prdata = lbds_pkg::DATA_W'(cfg_r.block_h);
      lbds_pkg::REG_INVERT_MODE:  prdata = lbds_pkg::DATA_W'(cfg_r.invert_mode);
      default:                    prdata = '0;
    endcase
  end

  lbds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lbds_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .cmd             (cmd),
    .sts             (sts),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_shade_char  (out_shade_char),
    .out_end_of_line (out_end_of_line)
  );

endmodule

`default_nettype wire

FILE: design/lbds_checker.sv
`default_nettype none

`include "assert_macros.svh"

module lbds_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [lbds_pkg::CHAR_W-1:0]  out_shade_char,
  input wire logic                         out_end_of_line,
  input wire logic                         pready
);

  logic shade_known;

  always_comb begin
    shade_known = 1'b0;
    for (int k = 0; k < lbds_pkg::NUM_LEVELS; k++) begin
      if (out_shade_char == lbds_pkg::SHADE_LUT[k]) shade_known = 1'b1;
    end
  end

  property p_out_hold;
    out_valid && out_stall |=>
      out_valid && $stable(out_shade_char) && $stable(out_end_of_line);
  endproperty

  `ASSERT_CLK(a_out_hold, p_out_hold, "stalled result beat changed")
  `ASSERT_CLK(a_one_at_a_time, in_valid && !in_stall |=> in_stall, "pixel taken while busy")
  `ASSERT_CLK(a_clear_after_reset, $rose(rst_n) |-> in_stall, "pixel taken during memory clear")
  `ASSERT_NEVER(a_shade_code, out_valid && !shade_known, "shade code outside table")
  `ASSERT_NEVER(a_pready, !pready, "pready dropped")

endmodule

bind luma_box_downscale_ascii_shade_unit lbds_checker u_lbds_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_shade_char  (out_shade_char),
  .out_end_of_line (out_end_of_line),
  .pready          (pready)
);

`default_nettype wire

FILE: tb/shade_cell_checker.sv
`timescale 1ns / 1ps

module shade_cell_checker
  import lbds_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_BLOCK = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         in_red,
  input  logic [7:0]         in_green,
  input  logic [7:0]         in_blue,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [CHAR_W-1:0]  out_shade_char,
  input  logic               out_end_of_line,
  output int                 mismatches,
  output int                 cells_pending,
  output int                 cells_checked
);

  typedef struct packed {
    logic [CHAR_W-1:0] shade;
    logic              eol;
  } cell_t;

  cell_t            cells_due[$];
  logic [SUM_W-1:0] col_sum [MAX_WIDTH];
  logic [DIM_W-1:0] img_w, img_h;
  logic [BLK_W-1:0] blk_w, blk_h;
  logic             invert;
  int unsigned      px_col, px_row, tile_x, tile_y, cell_x;
  int               errs = 0;
  int               checked = 0;

  function automatic int unsigned fit(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  task automatic shade_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int unsigned w, h, bw, bh, ncells, luma, sum, level;
    cell_t       c;
    w      = fit(img_w, MAX_WIDTH);
    h      = fit(img_h, HEIGHT_MAX);
    bw     = fit(blk_w, MAX_BLOCK);
    bh     = fit(blk_h, MAX_BLOCK);
    ncells = w / bw;
    luma   = (RED_COEF * r + GREEN_COEF * g + BLUE_COEF * b) >> 16;

    if (tile_y <= px_row && (px_row - tile_y) + bh <= h && cell_x < ncells) begin
      if (tile_y == 0 && tile_x == 0) sum = luma;
      else sum = col_sum[cell_x] + luma;
      if (sum > 65535) sum = 65535;
      col_sum[cell_x] = sum[SUM_W-1:0];
      if (tile_x == bw - 1 && tile_y == bh - 1) begin
        level = (sum / (bw * bh)) >> LEVEL_SHIFT;
        if (level > NUM_LEVELS - 1) level = NUM_LEVELS - 1;
        if (invert) level = NUM_LEVELS - 1 - level;
        c.shade = SHADE_LUT[level];
        c.eol   = (cell_x + 1 == ncells);
        cells_due.push_back(c);
      end
    end

    if (px_col + 1 >= w) begin
      px_col = 0;
      tile_x = 0;
      cell_x = 0;
      if (px_row + 1 >= h) begin
        px_row = 0;
        tile_y = 0;
      end else begin
        px_row++;
        tile_y = (tile_y + 1 >= bh) ? 0 : tile_y + 1;
      end
    end else begin
      px_col++;
      if (tile_x + 1 >= bw) begin
        tile_x = 0;
        if (cell_x < MAX_WIDTH) cell_x++;
      end else begin
        tile_x++;
      end
    end
  endtask

  task automatic compare_cell();
    cell_t want;
    if (cells_due.size() == 0) begin
      if (errs < 10)
        $display("%0t: unexpected shade beat %h eol %b", $time, out_shade_char,
                 out_end_of_line);
      errs++;
      return;
    end
    want = cells_due.pop_front();
    checked++;
    if (out_shade_char !== want.shade || out_end_of_line !== want.eol) begin
      if (errs < 10)
        $display("%0t: shade beat %0d expected %h eol %b, got %h eol %b", $time, checked,
                 want.shade, want.eol, out_shade_char, out_end_of_line);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      img_w  = IMAGE_WIDTH_RST;
      img_h  = IMAGE_HEIGHT_RST;
      blk_w  = BLOCK_W_RST;
      blk_h  = BLOCK_H_RST;
      invert = 1'b0;
      px_col = 0;
      px_row = 0;
      tile_x = 0;
      tile_y = 0;
      cell_x = 0;
      cells_due.delete();
      foreach (col_sum[i]) col_sum[i] = '0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_IMAGE_WIDTH:  img_w  = pwdata[DIM_W-1:0];
          REG_IMAGE_HEIGHT: img_h  = pwdata[DIM_W-1:0];
          REG_BLOCK_W:      blk_w  = pwdata[BLK_W-1:0];
          REG_BLOCK_H:      blk_h  = pwdata[BLK_W-1:0];
          REG_INVERT_MODE:  invert = pwdata[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) compare_cell();
      if (in_valid && !in_stall) shade_pixel(in_red, in_green, in_blue);
    end
    mismatches    <= errs;
    cells_pending <= cells_due.size();
    cells_checked <= checked;
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import lbds_pkg::*;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_BLOCK    = 16;
  localparam int RUN_LIMIT    = 200000;
  localparam int PIXEL_TARGET = 1400;
  localparam int SETTLE       = 12;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_PCT     = 14;
  localparam logic [7:0] GRAYS [10] = '{
    8'd0, 8'd31, 8'd32, 8'd95, 8'd96, 8'd128, 8'd160, 8'd191, 8'd224, 8'd255
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_red = '0;
  logic [7:0]         in_green = '0;
  logic [7:0]         in_blue = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CHAR_W-1:0]  out_shade_char;
  logic               out_end_of_line;

  int   cycle = 0;
  int   hold_at = -1;
  int   hold_left = 0;
  int   pixels_sent = 0;
  int   settings_used = 0;
  int   tone = 128;
  int   spread = 128;
  int   mismatches, cells_pending, cells_checked;
  logic quiet;

  assign quiet = (cycle >= 4000) && (cycle < 6500);

  luma_box_downscale_ascii_shade_unit #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_BLOCK(MAX_BLOCK)
  ) i_dut (
    .clk, .rst_n,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .in_red, .in_green, .in_blue,
    .out_valid, .out_stall, .out_shade_char, .out_end_of_line
  );

  shade_cell_checker #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_BLOCK(MAX_BLOCK)
  ) i_checker (
    .clk, .rst_n,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_valid, .in_stall, .in_red, .in_green, .in_blue,
    .out_valid, .out_stall, .out_shade_char, .out_end_of_line,
    .mismatches, .cells_pending, .cells_checked
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
  end

  // result side: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (cycle == hold_at) hold_left = HOLD_CYCLES;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  function automatic logic [7:0] pick_level();
    int v;
    if (spread != 0 && $urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    v = tone + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    pixels_sent++;
  endtask

  task automatic send_run(input int n);
    repeat (n) send_pixel(pick_level(), pick_level(), pick_level());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (cells_pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // junk above the register width must be ignored
  task automatic reg_write(input logic [2:0] idx, input int unsigned val);
    int unsigned bits;
    case (idx)
      REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT: bits = DIM_W;
      REG_BLOCK_W, REG_BLOCK_H:          bits = BLK_W;
      default:                           bits = 1;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= (val & ((32'd1 << bits) - 1)) | ($urandom << bits);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input int unsigned w, input int unsigned h, input int unsigned bw,
                            input int unsigned bh, input int unsigned inv);
    reg_write(REG_IMAGE_WIDTH, w);
    reg_write(REG_IMAGE_HEIGHT, h);
    reg_write(REG_BLOCK_W, bw);
    reg_write(REG_BLOCK_H, bh);
    reg_write(REG_INVERT_MODE, inv);
    settings_used++;
  endtask

  initial begin
    int kind, n, phase;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: one cell per pixel, all shade levels but 6, and the pure primaries
    for (int i = 0; i < 10; i++) send_pixel(GRAYS[i], GRAYS[i], GRAYS[i]);
    send_pixel(8'hFF, 8'h00, 8'h00);
    send_pixel(8'h00, 8'hFF, 8'h00);
    send_pixel(8'h00, 8'h00, 8'hFF);
    drain();

    // zero sizes act as one, written mid-row
    set_config(0, 0, 0, 0, 1);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hAA, 8'h55, 8'hAA);
    send_pixel(8'h55, 8'hAA, 8'h55);
    drain();

    // oversized values, then a tile wider than the image
    set_config(2047, 2047, 31, 31, 0);
    set_config(3, 1, 4, 1, 0);
    repeat (4) send_pixel(8'hFF, 8'hFF, 8'hFF);
    drain();

    // receiver holds off while the sender keeps going
    set_config(8, 4, 1, 1, 1);
    hold_at = cycle + 4;
    send_run(60);
    drain();

    phase = 0;
    while (pixels_sent < PIXEL_TARGET) begin
      kind   = (phase == 0) ? 1 : $urandom_range(0, 9);
      tone   = $urandom_range(0, 255);
      case ($urandom_range(0, 2))
        0:       spread = 0;
        1:       spread = 24;
        default: spread = 128;
      endcase
      case (kind)
        0: begin
          set_config($urandom_range(0, 1) ? 2047 : $urandom_range(600, 1024),
                     $urandom_range(1, 3), $urandom_range(8, 31), 1, $urandom_range(0, 1));
          n = 150;
        end
        1: begin
          set_config(16, 16, $urandom_range(16, 31), $urandom_range(16, 31),
                     $urandom_range(0, 1));
          if (phase == 0) begin
            tone   = 255;
            spread = 0;
          end
          n = 256;
        end
        2: begin
          set_config($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 2),
                     $urandom_range(0, 2), $urandom_range(0, 1));
          n = $urandom_range(10, 40);
        end
        default: begin
          set_config($urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(1, 4),
                     $urandom_range(1, 3), $urandom_range(0, 1));
          n = $urandom_range(20, 80);
        end
      endcase
      send_run(n);
      drain();
      phase++;
    end

    $display("%0d pixels under %0d register settings, %0d shade beats compared",
             pixels_sent, settings_used, cells_checked);
    if (cells_pending != 0) $display("%0d shade beats never arrived", cells_pending);
    if (mismatches == 0 && cells_pending == 0) begin
      $display("** luma_box_downscale_ascii_shade_unit: PASSED **");
    end else begin
      $display("** luma_box_downscale_ascii_shade_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    wait (cycle >= RUN_LIMIT);
    $display("run exceeded %0d cycles", RUN_LIMIT);
    $display("** luma_box_downscale_ascii_shade_unit: FAILED **");
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/lbds_pkg.sv
design/lbds_ctrl.sv
design/lbds_dp.sv
design/luma_box_downscale_ascii_shade_unit.sv
design/lbds_checker.sv
tb/shade_cell_checker.sv
tb/tb.sv
